/* hdl/tccw_pkg.sv */
package tccw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  // Field widths on the channels
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;

  // Internal widths
  localparam int PROW_W = $clog2(ROWS);
  localparam int WM_W   = $clog2(COLUMNS + 1);
  localparam int NCOL_W = $clog2(COLUMNS + 8);
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd15;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;

  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic load_item;
    logic rd_issue;
    logic rd_capture;
    logic fill;
    logic commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic in_range;
    logic gap;
    logic out_busy;
  } status_t;

endpackage

/* hdl/tccw_in_if.sv */
interface tccw_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [tccw_pkg::CHAR_W-1:0]   char_code;
  logic [tccw_pkg::ROW_W-1:0]    read_row;
  logic [tccw_pkg::COL_W-1:0]    read_col;

  modport source (output valid, output kind, output char_code, output read_row,
                  output read_col, input ready);
  modport sink   (input valid, input kind, input char_code, input read_row,
                  input read_col, output ready);
endinterface

/* hdl/tccw_out_if.sv */
interface tccw_out_if;
  logic                          valid;
  logic                          ready;
  logic [tccw_pkg::CELL_W-1:0]   cell_data;
  logic [tccw_pkg::ROW_W-1:0]    cursor_row;
  logic [tccw_pkg::COL_W-1:0]    cursor_col;
  logic                          scrolled;

  modport source (output valid, output cell_data, output cursor_row, output cursor_col,
                  output scrolled, input ready);
  modport sink   (input valid, input cell_data, input cursor_row, input cursor_col,
                  input scrolled, output ready);
endinterface

/* hdl/tccw_ctrl.sv */
module tccw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tccw_pkg::status_t status_i,
  output tccw_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RD_WAIT,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status_i.is_read && status_i.in_range) begin
          cmd_o.rd_issue = 1'b1;
          state_d        = S_RD_WAIT;
        end else if (status_i.gap) begin
          // tab left unwritten cells behind the cursor: fill them one per cycle
          cmd_o.fill = 1'b1;
        end else begin
          cmd_o.commit = 1'b1;
          state_d      = S_DONE;
        end
      end
      S_RD_WAIT: begin
        cmd_o.rd_capture = 1'b1;
        state_d          = S_DONE;
      end
      S_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/tccw_dp.sv */
module tccw_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tccw_pkg::cmd_t                cmd_i,
  output tccw_pkg::status_t             status_o,
  input  logic                          cfg_we_i,
  input  logic [tccw_pkg::ATTR_W-1:0]   cfg_data_i,
  input  logic                          kind_i,
  input  logic [tccw_pkg::CHAR_W-1:0]   char_code_i,
  input  logic [tccw_pkg::ROW_W-1:0]    read_row_i,
  input  logic [tccw_pkg::COL_W-1:0]    read_col_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tccw_pkg::CELL_W-1:0]   cell_data_o,
  output logic [tccw_pkg::ROW_W-1:0]    cursor_row_o,
  output logic [tccw_pkg::COL_W-1:0]    cursor_col_o,
  output logic                          scrolled_o
);

  // item register
  logic                        kind_q;
  logic [tccw_pkg::CHAR_W-1:0] char_q;
  logic [tccw_pkg::ROW_W-1:0]  rrow_q;
  logic [tccw_pkg::COL_W-1:0]  rcol_q;

  // console state
  logic [tccw_pkg::ATTR_W-1:0] colour_q;
  logic [tccw_pkg::ROW_W-1:0]  crow_q;
  logic [tccw_pkg::COL_W-1:0]  ccol_q;
  logic [tccw_pkg::PROW_W-1:0] top_q;

  // per physical row: columns below wm_q hold real data in the memory,
  // the rest read as the row fill (zero after reset, blank after a scroll)
  logic [tccw_pkg::WM_W-1:0]   wm_q    [tccw_pkg::ROWS];
  logic                        blank_q [tccw_pkg::ROWS];
  logic [tccw_pkg::ATTR_W-1:0] fcol_q  [tccw_pkg::ROWS];

  logic [tccw_pkg::CELL_W-1:0] cells_q [tccw_pkg::CELLS];
  logic [tccw_pkg::CELL_W-1:0] rdata_q;

  // result and output registers
  logic [tccw_pkg::CELL_W-1:0] res_cell_q;
  logic                        res_scr_q;
  logic                        out_valid_q;
  logic [tccw_pkg::CELL_W-1:0] out_cell_q;
  logic [tccw_pkg::ROW_W-1:0]  out_row_q;
  logic [tccw_pkg::COL_W-1:0]  out_col_q;
  logic                        out_scr_q;

  logic [tccw_pkg::ROW_W-1:0]  sel_row;
  logic [tccw_pkg::ROW_W:0]    prow_sum;
  logic [tccw_pkg::PROW_W-1:0] sel_prow;
  logic [tccw_pkg::WM_W-1:0]   wm_sel;
  logic [tccw_pkg::CELL_W-1:0] fill_sel;
  logic [tccw_pkg::WM_W-1:0]   ccol_wm;
  logic [tccw_pkg::ADDR_W-1:0] base_addr;
  logic [tccw_pkg::ADDR_W-1:0] mem_addr;
  logic [tccw_pkg::ADDR_W-1:0] col_off;
  logic                        mem_we;
  logic [tccw_pkg::CELL_W-1:0] mem_wdata;
  logic                        printable;
  logic                        in_range;
  logic [tccw_pkg::NCOL_W-1:0] col_ext;
  logic [tccw_pkg::NCOL_W-1:0] ncol;
  logic                        row_inc;
  logic                        wrap;
  logic [tccw_pkg::ROW_W:0]    nrow;
  logic                        scroll;
  logic [tccw_pkg::ROW_W-1:0]  crow_d;
  logic [tccw_pkg::COL_W-1:0]  ccol_d;
  logic [tccw_pkg::PROW_W-1:0] top_d;

  // physical row of the selected logical row, rows form a ring starting at top_q
  assign sel_row  = (kind_q == tccw_pkg::KIND_READ) ? rrow_q : crow_q;
  assign prow_sum = {1'b0, sel_row} + (tccw_pkg::ROW_W + 1)'(top_q);
  assign sel_prow = (int'(prow_sum) >= tccw_pkg::ROWS)
                  ? tccw_pkg::PROW_W'(int'(prow_sum) - tccw_pkg::ROWS)
                  : tccw_pkg::PROW_W'(prow_sum);

  assign wm_sel   = wm_q[sel_prow];
  assign fill_sel = blank_q[sel_prow] ? {fcol_q[sel_prow], tccw_pkg::CH_BLANK} : '0;
  assign ccol_wm  = tccw_pkg::WM_W'(ccol_q);

  assign printable = (char_q != tccw_pkg::CH_BACKSPACE) && (char_q != tccw_pkg::CH_TAB)
                  && (char_q != tccw_pkg::CH_NEWLINE) && (char_q != tccw_pkg::CH_RETURN);
  assign in_range  = (int'(rrow_q) < tccw_pkg::ROWS) && (int'(rcol_q) < tccw_pkg::COLUMNS);

  always_comb begin
    if (cmd_i.fill) begin
      col_off = tccw_pkg::ADDR_W'(wm_sel);
    end else if (kind_q == tccw_pkg::KIND_READ) begin
      col_off = tccw_pkg::ADDR_W'(rcol_q);
    end else begin
      col_off = tccw_pkg::ADDR_W'(ccol_q);
    end
  end

  assign base_addr = tccw_pkg::ADDR_W'(sel_prow) * tccw_pkg::ADDR_W'(tccw_pkg::COLUMNS);
  assign mem_addr  = base_addr + col_off;
  assign mem_we    = cmd_i.fill
                  | (cmd_i.commit & (kind_q == tccw_pkg::KIND_PUT) & printable);
  assign mem_wdata = cmd_i.fill ? fill_sel : {colour_q, char_q};

  // cursor motion for a put
  assign col_ext = tccw_pkg::NCOL_W'(ccol_q);

  always_comb begin
    row_inc = 1'b0;
    ncol    = col_ext;
    case (char_q)
      tccw_pkg::CH_NEWLINE: begin
        ncol    = '0;
        row_inc = 1'b1;
      end
      tccw_pkg::CH_RETURN: begin
        ncol = '0;
      end
      tccw_pkg::CH_TAB: begin
        ncol = (col_ext + tccw_pkg::NCOL_W'(8)) & ~tccw_pkg::NCOL_W'(7);
      end
      tccw_pkg::CH_BACKSPACE: begin
        if (col_ext != '0) begin
          ncol = col_ext - tccw_pkg::NCOL_W'(1);
        end
      end
      default: begin
        ncol = col_ext + tccw_pkg::NCOL_W'(1);
      end
    endcase
  end

  assign wrap   = (int'(ncol) >= tccw_pkg::COLUMNS);
  assign nrow   = {1'b0, crow_q} + (tccw_pkg::ROW_W + 1)'(row_inc | wrap);
  assign scroll = (int'(nrow) >= tccw_pkg::ROWS);
  assign crow_d = scroll ? tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1) : nrow[tccw_pkg::ROW_W-1:0];
  assign ccol_d = wrap ? '0 : tccw_pkg::COL_W'(ncol);
  assign top_d  = (int'(top_q) == tccw_pkg::ROWS - 1)
                ? '0 : top_q + tccw_pkg::PROW_W'(1);

  assign status_o.is_read  = (kind_q == tccw_pkg::KIND_READ);
  assign status_o.in_range = in_range;
  assign status_o.gap      = (kind_q == tccw_pkg::KIND_PUT) && printable && (ccol_wm > wm_sel);
  assign status_o.out_busy = out_valid_q & ~out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q <= kind_i;
      char_q <= char_code_i;
      rrow_q <= read_row_i;
      rcol_q <= read_col_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cells_q[mem_addr] <= mem_wdata;
    end
    if (cmd_i.rd_issue) begin
      rdata_q <= cells_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && (kind_q == tccw_pkg::KIND_PUT) && scroll) begin
      fcol_q[top_q] <= colour_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colour_q <= tccw_pkg::ATTR_RESET;
      crow_q   <= '0;
      ccol_q   <= '0;
      top_q    <= '0;
      for (int r = 0; r < tccw_pkg::ROWS; r++) begin
        wm_q[r]    <= '0;
        blank_q[r] <= 1'b0;
      end
    end else begin
      if (cfg_we_i) begin
        colour_q <= cfg_data_i;
      end
      if (cmd_i.fill) begin
        wm_q[sel_prow] <= wm_sel + tccw_pkg::WM_W'(1);
      end
      if (cmd_i.commit && (kind_q == tccw_pkg::KIND_PUT)) begin
        if (printable && (ccol_wm >= wm_sel)) begin
          wm_q[sel_prow] <= ccol_wm + tccw_pkg::WM_W'(1);
        end
        crow_q <= crow_d;
        ccol_q <= ccol_d;
        if (scroll) begin
          // old top row becomes the new bottom row, lazily blanked
          top_q          <= top_d;
          wm_q[top_q]    <= '0;
          blank_q[top_q] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_cell_q <= '0;
      res_scr_q  <= (kind_q == tccw_pkg::KIND_PUT) & scroll;
    end else if (cmd_i.rd_capture) begin
      res_cell_q <= (tccw_pkg::WM_W'(rcol_q) < wm_sel) ? rdata_q : fill_sel;
      res_scr_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_cell_q <= res_cell_q;
      out_row_q  <= crow_q;
      out_col_q  <= ccol_q;
      out_scr_q  <= res_scr_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_data_o  = out_cell_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;
  assign scrolled_o   = out_scr_q;

endmodule

/* hdl/text_console_cell_writer_unit.sv */
// Text console: an 80 x 25 grid of 16-bit cells (attribute high byte, character
// low byte) with a cursor, driven one character or one cell read per
// transaction. A printable character written after tabs that skipped
// unwritten cells is written only after the skipped cells are filled from
// the row fill (up to 72 of them when tabs carry the cursor across a fresh
// row). An in-range read goes through the registered read port of the cell
// memory; an out-of-range read skips it and returns a zero cell. Items are
// handled one at a time; the next item is accepted while a finished result
// still waits in the output register, and a result stalls only while the one
// before it is still waiting. Scrolling moves a ring offset over the rows
// and blanks the new bottom row lazily, without a pass over its cells, and no
// clearing pass is needed after reset. The colour register (reset 0x0F) may
// be written only while the console is idle.
module text_console_cell_writer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tccw_pkg::ATTR_W-1:0]   cfg_data_i,
  tccw_in_if.sink                       in_i,
  tccw_out_if.source                    out_o
);

  tccw_pkg::cmd_t    cmd;
  tccw_pkg::status_t status;
  logic              in_ready;

  tccw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tccw_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .kind_i       (in_i.kind),
    .char_code_i  (in_i.char_code),
    .read_row_i   (in_i.read_row),
    .read_col_i   (in_i.read_col),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .cell_data_o  (out_o.cell_data),
    .cursor_row_o (out_o.cursor_row),
    .cursor_col_o (out_o.cursor_col),
    .scrolled_o   (out_o.scrolled)
  );

  assign in_i.ready = in_ready;

  a_cursor_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (int'(out_o.cursor_col) < tccw_pkg::COLUMNS))
    else $error("cursor column past last column");

  a_scroll_bottom_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.scrolled) |-> (int'(out_o.cursor_row) == tccw_pkg::ROWS - 1))
    else $error("scroll reported with cursor off the last row");

  a_one_item_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready) |=> !in_ready)
    else $error("new transaction taken while previous item still in work");

endmodule
